/* rtl/qte_pkg.sv */
// shared types, constants and fixed-point helpers of the quartic trajectory evaluator
package qte_pkg;

  localparam int FRAC_BITS = 16;
  localparam int TIME_W    = 24;
  localparam int DATA_W    = 32;
  localparam int FX_W      = 64;
  localparam int HALF_W    = 32;
  localparam int WIDE_W    = 128;
  localparam int LANES     = 4;
  localparam int STEPS     = 4;
  localparam int CFG_IDX_W = 3;

  localparam logic [CFG_IDX_W-1:0] REG_START_POS = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_VEL = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_START_ACC = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_END_VEL   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_END_ACC   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DURATION  = 3'd5;

  localparam logic [TIME_W-1:0] DURATION_RESET = TIME_W'(1) << FRAC_BITS;

  typedef logic signed [FX_W-1:0] fx_t;

  localparam fx_t FX_LIM  = (fx_t'(1) <<< (FX_W-2)) - fx_t'(1);
  localparam fx_t OUT_MAX = (fx_t'(1) <<< (DATA_W-1)) - fx_t'(1);
  localparam fx_t OUT_MIN = -OUT_MAX - fx_t'(1);
  localparam logic [WIDE_W-1:0] RND_HALF = WIDE_W'(1) << (FRAC_BITS-1);

  typedef struct packed {
    fx_t  v;
    logic sat;
  } fxs_t;

  // one item in flight: horner accumulators of the four lanes
  typedef struct packed {
    fx_t [LANES-1:0]   h;
    logic [LANES-1:0]  sat;
    logic [TIME_W-1:0] t;
  } item_t;

  // solved coefficients and solver status
  typedef struct packed {
    fx_t [LANES-1:0]            h0;
    fx_t [STEPS-1:0][LANES-1:0] c;
    logic                       sat;
    logic                       zero;
    logic                       busy;
  } coef_t;

  typedef struct packed {
    logic                 en;
    logic [CFG_IDX_W-1:0] idx;
    logic [DATA_W-1:0]    data;
  } cfg_wr_t;

  function automatic logic [FX_W-1:0] fx_mag(fx_t a);
    return a[FX_W-1] ? FX_W'(-a) : FX_W'(a);
  endfunction

  function automatic fxs_t fx_clamp(logic [WIDE_W-1:0] mag, logic neg);
    fxs_t r;
    fx_t  m;
    r.sat = 1'b0;
    if (mag > WIDE_W'(FX_LIM)) begin
      r.sat = 1'b1;
      m = FX_LIM;
    end else begin
      m = mag[FX_W-1:0];
    end
    r.v = neg ? -m : m;
    return r;
  endfunction

  function automatic fxs_t fx_add(fx_t a, fx_t b);
    logic signed [FX_W:0] s;
    logic signed [FX_W:0] lim;
    fxs_t r;
    lim = {1'b0, FX_LIM};
    s = $signed({a[FX_W-1], a}) + $signed({b[FX_W-1], b});
    r.sat = 1'b0;
    r.v = s[FX_W-1:0];
    if (s > lim) begin
      r.sat = 1'b1;
      r.v = FX_LIM;
    end else if (s < -lim) begin
      r.sat = 1'b1;
      r.v = -FX_LIM;
    end
    return r;
  endfunction

  function automatic fxs_t fx_scale(fx_t a, logic [4:0] k);
    logic [WIDE_W-1:0] p;
    p = WIDE_W'(fx_mag(a)) * WIDE_W'(k);
    return fx_clamp(p, a[FX_W-1]);
  endfunction

endpackage

/* rtl/qte_in_if.sv */
// time sample request channel
interface qte_in_if;
  logic                        valid;
  logic                        ready;
  logic [qte_pkg::TIME_W-1:0]  eval_time;
  modport source (output valid, output eval_time, input ready);
  modport sink (input valid, input eval_time, output ready);
endinterface

/* rtl/qte_out_if.sv */
// trajectory sample result channel
interface qte_out_if;
  logic                              valid;
  logic                              ready;
  logic signed [qte_pkg::DATA_W-1:0] position;
  logic signed [qte_pkg::DATA_W-1:0] velocity;
  logic signed [qte_pkg::DATA_W-1:0] acceleration;
  logic signed [qte_pkg::DATA_W-1:0] jerk;
  logic                              overflow;
  logic                              zero_duration;
  modport source (output valid, output position, output velocity, output acceleration,
                  output jerk, output overflow, output zero_duration, input ready);
  modport sink (input valid, input position, input velocity, input acceleration,
                input jerk, input overflow, input zero_duration, output ready);
endinterface

/* rtl/qte_cfg_if.sv */
// register write channel
interface qte_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [qte_pkg::CFG_IDX_W-1:0] index;
  logic [qte_pkg::DATA_W-1:0]    data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

/* rtl/quartic_trajectory_evaluator_top.sv */
// top level of the quartic trajectory evaluator: solver, horner pipeline, output register
//
//  channel   dir  handshake        payload
//  in_if     in   valid / ready    eval_time (unsigned, 24 bit)
//  out_if    out  valid / ready    position, velocity, acceleration, jerk, overflow,
//                                  zero_duration
//  cfg_if    in   valid / ready    index (3 bit), data (32 bit); ready is always high
//
//  one sample per cycle unless the solver is busy or out_if stalls; four horner steps of three
//    stages, one output stage; after any register write the solver finds the coefficients with
//    four 128-bit divisions at one bit a cycle, skipped for zero duration; in_if.ready stays low
//  reset (synchronous, rst_n low) loads the register defaults, whose coefficients are all zero
//  a stall on out_if holds each stage whose successor is full; bubbles close up
module quartic_trajectory_evaluator_top (
  input logic       clk,
  input logic       rst_n,
  qte_in_if.sink    in_if,
  qte_out_if.source out_if,
  qte_cfg_if.sink   cfg_if
);

  qte_pkg::coef_t   coef;
  qte_pkg::cfg_wr_t wr;

  logic           hs_valid [qte_pkg::STEPS+1];
  logic           hs_ready [qte_pkg::STEPS+1];
  qte_pkg::item_t hs_item  [qte_pkg::STEPS+1];

  logic                              out_valid_r;
  logic                              en_out;
  logic signed [qte_pkg::DATA_W-1:0] val_r [qte_pkg::LANES];
  logic signed [qte_pkg::DATA_W-1:0] val_nxt [qte_pkg::LANES];
  logic                              ov_r, ov_nxt, zd_r, zd_nxt;

  // clamp to the 32-bit result range, top bit flags a clamp
  function automatic logic [qte_pkg::DATA_W:0] clamp_out(qte_pkg::fx_t x);
    if (x > qte_pkg::OUT_MAX) return {1'b1, qte_pkg::OUT_MAX[qte_pkg::DATA_W-1:0]};
    if (x < qte_pkg::OUT_MIN) return {1'b1, qte_pkg::OUT_MIN[qte_pkg::DATA_W-1:0]};
    return {1'b0, x[qte_pkg::DATA_W-1:0]};
  endfunction

  // register writes, always taken
  assign cfg_if.ready = 1'b1;
  always_comb begin
    wr.en   = cfg_if.valid && cfg_if.ready;
    wr.idx  = cfg_if.index;
    wr.data = cfg_if.data;
  end

  qte_solve u_solve (
    .clk   (clk),
    .rst_n (rst_n),
    .wr    (wr),
    .coef  (coef)
  );

  // requests enter only once the coefficients are settled
  assign in_if.ready = hs_ready[0] && !coef.busy;
  assign hs_valid[0] = in_if.valid && !coef.busy;
  always_comb begin
    hs_item[0]     = '0;
    hs_item[0].h   = coef.h0;
    hs_item[0].t   = in_if.eval_time;
  end

  for (genvar s = 0; s < qte_pkg::STEPS; s++) begin : g_step
    qte_hstep u_step (
      .clk     (clk),
      .rst_n   (rst_n),
      .i_valid (hs_valid[s]),
      .i_ready (hs_ready[s]),
      .i_item  (hs_item[s]),
      .coef    (coef.c[s]),
      .o_valid (hs_valid[s+1]),
      .o_ready (hs_ready[s+1]),
      .o_item  (hs_item[s+1])
    );
  end

  // output register: final clamp, overflow and zero duration override
  assign en_out                   = !out_valid_r || out_if.ready;
  assign hs_ready[qte_pkg::STEPS] = en_out;

  always_comb begin
    logic [qte_pkg::DATA_W:0] c;
    ov_nxt = (|hs_item[qte_pkg::STEPS].sat) | coef.sat;
    zd_nxt = coef.zero;
    for (int l = 0; l < qte_pkg::LANES; l++) begin
      c = clamp_out(hs_item[qte_pkg::STEPS].h[l]);
      val_nxt[l] = c[qte_pkg::DATA_W-1:0];
      ov_nxt = ov_nxt | c[qte_pkg::DATA_W];
    end
    if (coef.zero) begin
      for (int l = 0; l < qte_pkg::LANES; l++) begin
        val_nxt[l] = '0;
      end
      ov_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (en_out) begin
      out_valid_r <= hs_valid[qte_pkg::STEPS];
    end
  end

  always_ff @(posedge clk) begin
    if (en_out) begin
      val_r <= val_nxt;
      ov_r  <= ov_nxt;
      zd_r  <= zd_nxt;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.position      = val_r[0];
  assign out_if.velocity      = val_r[1];
  assign out_if.acceleration  = val_r[2];
  assign out_if.jerk          = val_r[3];
  assign out_if.overflow      = ov_r;
  assign out_if.zero_duration = zd_r;

`ifndef SYNTHESIS
  // no request is taken while the coefficients are being solved
  a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_if.valid && in_if.ready) |-> !coef.busy)
    else $error("request accepted while solver busy");

  // a register write always restarts the solver
  a_write_restarts: assert property (@(posedge clk) disable iff (!rst_n)
    (cfg_if.valid && cfg_if.ready) |=> coef.busy)
    else $error("solver not restarted after write");

  // zero duration results are all zero with no overflow
  a_zero_result: assert property (@(posedge clk) disable iff (!rst_n)
    (out_if.valid && out_if.zero_duration) |->
      (out_if.position == '0 && out_if.velocity == '0 && out_if.acceleration == '0 &&
       out_if.jerk == '0 && !out_if.overflow))
    else $error("zero duration result not cleared");
`endif

endmodule

/* rtl/qte_div.sv */
// bit-serial restoring divider, one quotient bit per cycle
module qte_div (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  input  logic [qte_pkg::WIDE_W-1:0]  num,
  input  logic [qte_pkg::FX_W-1:0]    den,
  output logic                        done,
  output logic [qte_pkg::WIDE_W-1:0]  quo
);

  localparam int CNT_W = $clog2(qte_pkg::WIDE_W);
  localparam logic [CNT_W-1:0] CNT_LAST = CNT_W'(qte_pkg::WIDE_W - 1);

  logic                       run_r;
  logic                       done_r;
  logic [CNT_W-1:0]           cnt_r;
  logic [qte_pkg::WIDE_W-1:0] num_r;
  logic [qte_pkg::WIDE_W-1:0] quo_r;
  logic [qte_pkg::FX_W-1:0]   rem_r;
  logic [qte_pkg::FX_W-1:0]   den_r;
  logic [qte_pkg::FX_W-1:0]   rem_sh;
  logic [qte_pkg::FX_W-1:0]   rem_nxt;
  logic                       q_bit;

  always_comb begin
    rem_sh  = {rem_r[qte_pkg::FX_W-2:0], num_r[qte_pkg::WIDE_W-1]};
    q_bit   = rem_sh >= den_r;
    rem_nxt = q_bit ? rem_sh - den_r : rem_sh;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= '0;
      end else if (run_r) begin
        cnt_r <= cnt_r + CNT_W'(1);
        if (cnt_r == CNT_LAST) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      num_r <= num;
      den_r <= den;
      rem_r <= '0;
      quo_r <= '0;
    end else if (run_r) begin
      num_r <= num_r << 1;
      rem_r <= rem_nxt;
      quo_r <= {quo_r[qte_pkg::WIDE_W-2:0], q_bit};
    end
  end

  assign done = done_r;
  assign quo  = quo_r;

endmodule

/* rtl/qte_solve.sv */
// configuration registers and sequential solver of the quartic coefficients
module qte_solve (
  input  logic             clk,
  input  logic             rst_n,
  input  qte_pkg::cfg_wr_t wr,
  output qte_pkg::coef_t   coef
);

  localparam logic [3:0] ST_IDLE  = 4'd0;
  localparam logic [3:0] ST_MUL   = 4'd1;
  localparam logic [3:0] ST_SUB   = 4'd2;
  localparam logic [3:0] ST_DIVC  = 4'd3;
  localparam logic [3:0] ST_DIVQ2 = 4'd4;
  localparam logic [3:0] ST_DIVQ3 = 4'd5;
  localparam logic [3:0] ST_DIVQ4 = 4'd6;
  localparam logic [3:0] ST_COMB  = 4'd7;
  localparam logic [3:0] ST_SCALE = 4'd8;

  localparam int PROD_W = qte_pkg::DATA_W + qte_pkg::TIME_W;
  localparam int T2_W   = 2 * qte_pkg::TIME_W;

  logic [3:0] st_r;
  logic       launched_r;
  logic       sat_r;
  logic       zero_r;

  logic signed [qte_pkg::DATA_W-1:0] xs_r, vs_r, as_r, ve_r, ae_r;
  logic [qte_pkg::TIME_W-1:0]        dur_r;

  qte_pkg::fx_t p_r, t2_r, b1_r, b2_r, c_r, q2_r, q3_r, q4_r;
  qte_pkg::fx_t a2_r, a3_r, a4_r;
  qte_pkg::fx_t a4x4_r, a3x3_r, a4x12_r, a3x6_r, a4x24_r;

  logic                       div_start, div_done, div_neg, div_st;
  logic [qte_pkg::WIDE_W-1:0] div_num, div_quo;
  logic [qte_pkg::FX_W-1:0]   div_den;

  logic [qte_pkg::DATA_W-1:0] as_mag;
  logic [PROD_W-1:0]          as_prod;
  logic [qte_pkg::FX_W-1:0]   a2_mag;
  qte_pkg::fxs_t p_q, sub1, sub2, b2_q, q_q, r3, r4;
  qte_pkg::fxs_t s4, s3, s12, s6, s24;
  qte_pkg::fx_t  a2_v;

  function automatic logic [qte_pkg::WIDE_W-1:0] dividend(qte_pkg::fx_t a,
      logic [qte_pkg::FX_W-1:0] d, logic dbl);
    logic [qte_pkg::WIDE_W-1:0] m;
    m = qte_pkg::WIDE_W'(qte_pkg::fx_mag(a));
    m = dbl ? (m << (2 * qte_pkg::FRAC_BITS)) : (m << qte_pkg::FRAC_BITS);
    return m + qte_pkg::WIDE_W'(d >> 1);
  endfunction

  qte_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .done  (div_done),
    .quo   (div_quo)
  );

  always_comb begin
    div_num = '0;
    div_den = '0;
    div_neg = 1'b0;
    unique case (st_r)
      ST_DIVC: begin
        div_num = dividend(b1_r, t2_r, 1'b1);
        div_den = t2_r;
        div_neg = b1_r[qte_pkg::FX_W-1];
      end
      ST_DIVQ2: begin
        div_den = qte_pkg::FX_W'(dur_r) + (qte_pkg::FX_W'(dur_r) << 1);
        div_num = dividend(b2_r, div_den, 1'b0);
        div_neg = b2_r[qte_pkg::FX_W-1];
      end
      ST_DIVQ3: begin
        div_den = t2_r << 2;
        div_num = dividend(b2_r, div_den, 1'b1);
        div_neg = b2_r[qte_pkg::FX_W-1];
      end
      ST_DIVQ4: begin
        div_den = qte_pkg::FX_W'(dur_r) << 1;
        div_num = dividend(c_r, div_den, 1'b0);
        div_neg = c_r[qte_pkg::FX_W-1];
      end
      default: ;
    endcase
    div_st    = (st_r == ST_DIVC) || (st_r == ST_DIVQ2) ||
                (st_r == ST_DIVQ3) || (st_r == ST_DIVQ4);
    div_start = div_st && !launched_r && !wr.en;
    q_q       = qte_pkg::fx_clamp(div_quo, div_neg);
  end

  always_comb begin
    as_mag  = as_r[qte_pkg::DATA_W-1] ? qte_pkg::DATA_W'(-as_r) : qte_pkg::DATA_W'(as_r);
    as_prod = PROD_W'(as_mag) * PROD_W'(dur_r);
    p_q     = qte_pkg::fx_clamp((qte_pkg::WIDE_W'(as_prod) + qte_pkg::RND_HALF)
                                >> qte_pkg::FRAC_BITS, as_r[qte_pkg::DATA_W-1]);
    sub1    = qte_pkg::fx_add(qte_pkg::FX_W'(ve_r), -qte_pkg::FX_W'(vs_r));
    sub2    = qte_pkg::fx_add(sub1.v, -p_r);
    b2_q    = qte_pkg::fx_add(qte_pkg::FX_W'(ae_r), -qte_pkg::FX_W'(as_r));
    r3      = qte_pkg::fx_add(c_r, -q2_r);
    r4      = qte_pkg::fx_add(q3_r, -q4_r);
    a2_mag  = (qte_pkg::FX_W'(as_mag) + qte_pkg::FX_W'(1)) >> 1;
    a2_v    = as_r[qte_pkg::DATA_W-1] ? -qte_pkg::fx_t'(a2_mag) : qte_pkg::fx_t'(a2_mag);
    s4      = qte_pkg::fx_scale(a4_r, 5'd4);
    s3      = qte_pkg::fx_scale(a3_r, 5'd3);
    s12     = qte_pkg::fx_scale(a4_r, 5'd12);
    s6      = qte_pkg::fx_scale(a3_r, 5'd6);
    s24     = qte_pkg::fx_scale(a4_r, 5'd24);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r       <= ST_IDLE;
      launched_r <= 1'b0;
      sat_r      <= 1'b0;
      zero_r     <= 1'b0;
      xs_r       <= '0;
      vs_r       <= '0;
      as_r       <= '0;
      ve_r       <= '0;
      ae_r       <= '0;
      dur_r      <= qte_pkg::DURATION_RESET;
      a2_r       <= '0;
      a3_r       <= '0;
      a4_r       <= '0;
      a4x4_r     <= '0;
      a3x3_r     <= '0;
      a4x12_r    <= '0;
      a3x6_r     <= '0;
      a4x24_r    <= '0;
    end else if (wr.en) begin
      unique case (wr.idx)
        qte_pkg::REG_START_POS: xs_r  <= wr.data;
        qte_pkg::REG_START_VEL: vs_r  <= wr.data;
        qte_pkg::REG_START_ACC: as_r  <= wr.data;
        qte_pkg::REG_END_VEL:   ve_r  <= wr.data;
        qte_pkg::REG_END_ACC:   ae_r  <= wr.data;
        qte_pkg::REG_DURATION:  dur_r <= wr.data[qte_pkg::TIME_W-1:0];
        default: ;
      endcase
      st_r       <= ST_MUL;
      launched_r <= 1'b0;
    end else begin
      if (div_start) begin
        launched_r <= 1'b1;
      end
      unique case (st_r)
        ST_MUL: begin
          p_r    <= p_q.v;
          sat_r  <= p_q.sat;
          t2_r   <= qte_pkg::FX_W'(T2_W'(dur_r) * T2_W'(dur_r));
          zero_r <= dur_r == '0;
          st_r   <= (dur_r == '0) ? ST_IDLE : ST_SUB;
        end
        ST_SUB: begin
          b1_r  <= sub2.v;
          b2_r  <= b2_q.v;
          sat_r <= sat_r | sub1.sat | sub2.sat | b2_q.sat;
          st_r  <= ST_DIVC;
        end
        ST_DIVC, ST_DIVQ2, ST_DIVQ3, ST_DIVQ4: begin
          if (launched_r && div_done) begin
            launched_r <= 1'b0;
            sat_r      <= sat_r | q_q.sat;
            unique case (st_r)
              ST_DIVC: begin
                c_r  <= q_q.v;
                st_r <= ST_DIVQ2;
              end
              ST_DIVQ2: begin
                q2_r <= q_q.v;
                st_r <= ST_DIVQ3;
              end
              ST_DIVQ3: begin
                q3_r <= q_q.v;
                st_r <= ST_DIVQ4;
              end
              default: begin
                q4_r <= q_q.v;
                st_r <= ST_COMB;
              end
            endcase
          end
        end
        ST_COMB: begin
          a3_r  <= r3.v;
          a4_r  <= r4.v;
          a2_r  <= a2_v;
          sat_r <= sat_r | r3.sat | r4.sat;
          st_r  <= ST_SCALE;
        end
        ST_SCALE: begin
          a4x4_r  <= s4.v;
          a3x3_r  <= s3.v;
          a4x12_r <= s12.v;
          a3x6_r  <= s6.v;
          a4x24_r <= s24.v;
          sat_r   <= sat_r | s4.sat | s3.sat | s12.sat | s6.sat | s24.sat;
          st_r    <= ST_IDLE;
        end
        default: ;
      endcase
    end
  end

  // lanes: position, velocity, acceleration, jerk; leading zero steps align the shorter ones
  always_comb begin
    coef         = '0;
    coef.h0[0]   = a4_r;
    coef.c[0][0] = a3_r;
    coef.c[0][1] = a4x4_r;
    coef.c[1][0] = a2_r;
    coef.c[1][1] = a3x3_r;
    coef.c[1][2] = a4x12_r;
    coef.c[2][0] = qte_pkg::FX_W'(vs_r);
    coef.c[2][1] = qte_pkg::FX_W'(as_r);
    coef.c[2][2] = a3x6_r;
    coef.c[2][3] = a4x24_r;
    coef.c[3][0] = qte_pkg::FX_W'(xs_r);
    coef.c[3][1] = qte_pkg::FX_W'(vs_r);
    coef.c[3][2] = qte_pkg::FX_W'(as_r);
    coef.c[3][3] = a3x6_r;
    coef.sat     = sat_r;
    coef.zero    = zero_r;
    coef.busy    = st_r != ST_IDLE;
  end

endmodule

/* rtl/qte_hstep.sv */
// one horner step for all four lanes: split multiply, round and clamp, add
module qte_hstep (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 i_valid,
  output logic                                 i_ready,
  input  qte_pkg::item_t                       i_item,
  input  qte_pkg::fx_t [qte_pkg::LANES-1:0]    coef,
  output logic                                 o_valid,
  input  logic                                 o_ready,
  output qte_pkg::item_t                       o_item
);

  localparam int PP_LO_W = qte_pkg::HALF_W + qte_pkg::TIME_W;
  localparam int PP_HI_W = qte_pkg::FX_W - 1 - qte_pkg::HALF_W + qte_pkg::TIME_W;

  logic v1_r, v2_r, v3_r;
  logic en1, en2, en3;

  logic [PP_LO_W-1:0]         pp_lo_r   [qte_pkg::LANES];
  logic [PP_HI_W-1:0]         pp_hi_r   [qte_pkg::LANES];
  logic [PP_LO_W-1:0]         pp_lo_nxt [qte_pkg::LANES];
  logic [PP_HI_W-1:0]         pp_hi_nxt [qte_pkg::LANES];
  logic [qte_pkg::LANES-1:0]  neg1_r, neg1_nxt, sat1_r, sat2_r, sat2_nxt;
  logic [qte_pkg::TIME_W-1:0] t1_r, t2_r;
  qte_pkg::fx_t               p2_r   [qte_pkg::LANES];
  qte_pkg::fx_t               p2_nxt [qte_pkg::LANES];
  qte_pkg::item_t             item3_r, item3_nxt;

  assign en3     = !v3_r || o_ready;
  assign en2     = !v2_r || en3;
  assign en1     = !v1_r || en2;
  assign i_ready = en1;
  assign o_valid = v3_r;
  assign o_item  = item3_r;

  always_comb begin
    logic [qte_pkg::FX_W-1:0] mag;
    for (int l = 0; l < qte_pkg::LANES; l++) begin
      mag          = qte_pkg::fx_mag(i_item.h[l]);
      neg1_nxt[l]  = i_item.h[l][qte_pkg::FX_W-1];
      pp_lo_nxt[l] = PP_LO_W'(mag[qte_pkg::HALF_W-1:0]) * PP_LO_W'(i_item.t);
      pp_hi_nxt[l] = PP_HI_W'(mag[qte_pkg::FX_W-2:qte_pkg::HALF_W]) * PP_HI_W'(i_item.t);
    end
  end

  always_comb begin
    logic [qte_pkg::WIDE_W-1:0] full;
    qte_pkg::fxs_t              r;
    for (int l = 0; l < qte_pkg::LANES; l++) begin
      full = (qte_pkg::WIDE_W'(pp_hi_r[l]) << qte_pkg::HALF_W) +
             qte_pkg::WIDE_W'(pp_lo_r[l]) + qte_pkg::RND_HALF;
      r = qte_pkg::fx_clamp(full >> qte_pkg::FRAC_BITS, neg1_r[l]);
      p2_nxt[l]   = r.v;
      sat2_nxt[l] = sat1_r[l] | r.sat;
    end
  end

  always_comb begin
    qte_pkg::fxs_t r;
    item3_nxt   = '0;
    item3_nxt.t = t2_r;
    for (int l = 0; l < qte_pkg::LANES; l++) begin
      r = qte_pkg::fx_add(coef[l], p2_r[l]);
      item3_nxt.h[l]   = r.v;
      item3_nxt.sat[l] = sat2_r[l] | r.sat;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (en1) v1_r <= i_valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      pp_lo_r <= pp_lo_nxt;
      pp_hi_r <= pp_hi_nxt;
      neg1_r  <= neg1_nxt;
      sat1_r  <= i_item.sat;
      t1_r    <= i_item.t;
    end
    if (en2) begin
      p2_r   <= p2_nxt;
      sat2_r <= sat2_nxt;
      t2_r   <= t1_r;
    end
    if (en3) begin
      item3_r <= item3_nxt;
    end
  end

endmodule
